// ===== rtl/mbd_pkg.sv =====
// package with region codes, opcodes, address constants and the boot image
`timescale 1ns / 1ps
package mbd_pkg;
	typedef enum logic [2:0] {
		OP_READ  = 3'd0,
		OP_WRITE = 3'd1,
		OP_RAISE = 3'd2,
		OP_ACK   = 3'd3,
		OP_TICK  = 3'd4
	} opcode_t;

	typedef enum logic [3:0] {
		RG_BOOT    = 4'd0,
		RG_CROM    = 4'd1,
		RG_VRAM    = 4'd2,
		RG_CRAM    = 4'd3,
		RG_WRAM    = 4'd4,
		RG_OAM     = 4'd5,
		RG_JOY     = 4'd6,
		RG_TIMER   = 4'd7,
		RG_IF      = 4'd8,
		RG_DMA     = 4'd9,
		RG_VIDEO   = 4'd10,
		RG_BOOTOFF = 4'd11,
		RG_HRAM    = 4'd12,
		RG_IE      = 4'd13,
		RG_NONE    = 4'd14
	} region_t;

	localparam logic [15:0] ADDR_CROM_END  = 16'h7fff;
	localparam logic [15:0] ADDR_VRAM_END  = 16'h9fff;
	localparam logic [15:0] ADDR_CRAM_END  = 16'hbfff;
	localparam logic [15:0] ADDR_WRAM_END  = 16'hfdff;
	localparam logic [15:0] ADDR_OAM_END   = 16'hfe9f;
	localparam logic [15:0] ADDR_JOY       = 16'hff00;
	localparam logic [15:0] ADDR_TIMER_LO  = 16'hff04;
	localparam logic [15:0] ADDR_TIMER_HI  = 16'hff07;
	localparam logic [15:0] ADDR_IF        = 16'hff0f;
	localparam logic [15:0] ADDR_VIDEO_LO  = 16'hff40;
	localparam logic [15:0] ADDR_VIDEO_HI  = 16'hff4b;
	localparam logic [15:0] ADDR_DMA       = 16'hff46;
	localparam logic [15:0] ADDR_BOOTOFF   = 16'hff50;
	localparam logic [15:0] ADDR_HRAM_LO   = 16'hff80;
	localparam logic [15:0] ADDR_HRAM_HI   = 16'hfffe;
	localparam logic [15:0] ADDR_IE        = 16'hffff;
	localparam logic [15:0] BANK_MASK      = 16'h1fff;
	localparam logic [7:0]  IRQ_MASK       = 8'h1f;

	localparam logic [7:0] BOOT_IMAGE [256] = '{
		8'h31,8'hfe,8'hff,8'haf,8'h21,8'hff,8'h9f,8'h32,8'hcb,8'h7c,8'h20,8'hfb,8'h21,8'h26,8'hff,8'h0e,
		8'h11,8'h3e,8'h80,8'h32,8'he2,8'h0c,8'h3e,8'hf3,8'he2,8'h32,8'h3e,8'h77,8'h77,8'h3e,8'hfc,8'he0,
		8'h47,8'h11,8'h04,8'h01,8'h21,8'h10,8'h80,8'h1a,8'hcd,8'h95,8'h00,8'hcd,8'h96,8'h00,8'h13,8'h7b,
		8'hfe,8'h34,8'h20,8'hf3,8'h11,8'hd8,8'h00,8'h06,8'h08,8'h1a,8'h13,8'h22,8'h23,8'h05,8'h20,8'hf9,
		8'h3e,8'h19,8'hea,8'h10,8'h99,8'h21,8'h2f,8'h99,8'h0e,8'h0c,8'h3d,8'h28,8'h08,8'h32,8'h0d,8'h20,
		8'hf9,8'h2e,8'h0f,8'h18,8'hf3,8'h67,8'h3e,8'h64,8'h57,8'he0,8'h42,8'h3e,8'h91,8'he0,8'h40,8'h04,
		8'h1e,8'h02,8'h0e,8'h0c,8'hf0,8'h44,8'hfe,8'h90,8'h20,8'hfa,8'h0d,8'h20,8'hf7,8'h1d,8'h20,8'hf2,
		8'h0e,8'h13,8'h24,8'h7c,8'h1e,8'h83,8'hfe,8'h62,8'h28,8'h06,8'h1e,8'hc1,8'hfe,8'h64,8'h20,8'h06,
		8'h7b,8'he2,8'h0c,8'h3e,8'h87,8'he2,8'hf0,8'h42,8'h90,8'he0,8'h42,8'h15,8'h20,8'hd2,8'h05,8'h20,
		8'h4f,8'h16,8'h20,8'h18,8'hcb,8'h4f,8'h06,8'h04,8'hc5,8'hcb,8'h11,8'h17,8'hc1,8'hcb,8'h11,8'h17,
		8'h05,8'h20,8'hf5,8'h22,8'h23,8'h22,8'h23,8'hc9,8'hce,8'hed,8'h66,8'h66,8'hcc,8'h0d,8'h00,8'h0b,
		8'h03,8'h73,8'h00,8'h83,8'h00,8'h0c,8'h00,8'h0d,8'h00,8'h08,8'h11,8'h1f,8'h88,8'h89,8'h00,8'h0e,
		8'hdc,8'hcc,8'h6e,8'he6,8'hdd,8'hdd,8'hd9,8'h99,8'hbb,8'hbb,8'h67,8'h63,8'h6e,8'h0e,8'hec,8'hcc,
		8'hdd,8'hdc,8'h99,8'h9f,8'hbb,8'hb9,8'h33,8'h3e,8'h3c,8'h42,8'hb9,8'ha5,8'hb9,8'ha5,8'h42,8'h3c,
		8'h21,8'h04,8'h01,8'h11,8'ha8,8'h00,8'h1a,8'h13,8'hbe,8'h20,8'hfe,8'h23,8'h7d,8'hfe,8'h34,8'h20,
		8'hf5,8'h06,8'h19,8'h78,8'h86,8'h23,8'h05,8'h20,8'hfb,8'h86,8'h20,8'hfe,8'h3e,8'h01,8'he0,8'h50
	};
endpackage

// ===== rtl/memory_bus_decoder_with_irq_and_dma.sv =====
// memory bus decoder: top level with decode, ram stage and output register
// pipeline: an accepted transaction is registered in stage 1 and then in the output register
// throughput: one transaction per cycle while the output is not stalled; the work and high ram ports each do one
//   read or one write per cycle, and a read right after a write sees the new byte
// reset: arst_n clears irq, dma and output valid state and sets the boot overlay;
//   the ram contents are undefined until written and need no clearing pass
`timescale 1ns / 1ps
module memory_bus_decoder_with_irq_and_dma import mbd_pkg::*; #(
	parameter int WRAM_DEPTH = 8192,
	parameter int HRAM_DEPTH = 127,
	parameter int DMA_LENGTH = 160
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  opcode,
	input  logic [15:0] address,
	input  logic [7:0]  write_data,
	input  logic [4:0]  irq_lines,
	input  logic [2:0]  ack_index,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  region,
	output logic [15:0] local_offset,
	output logic [7:0]  read_data,
	output logic        data_internal,
	output logic        dma_request,
	output logic [7:0]  dma_oam_index,
	output logic        dma_busy,
	output logic [4:0]  pending_irqs,
	output logic [4:0]  enabled_irqs,
	output logic        boot_overlay_on
);
	localparam int WAW = $clog2(WRAM_DEPTH);
	localparam int HAW = $clog2(HRAM_DEPTH);

	typedef enum logic [1:0] {
		SRC_NONE = 2'd0,
		SRC_REG  = 2'd1,
		SRC_WRAM = 2'd2,
		SRC_HRAM = 2'd3
	} src_t;

	// stage 1 registers
	logic           v_s1;
	logic [3:0]     region_s1;
	logic [15:0]    offset_s1;
	src_t           src_s1;
	logic [7:0]     regdata_s1;
	logic           req_s1;
	logic [7:0]     oam_s1;
	logic           busy_s1;
	logic [4:0]     pend_s1, en_s1;
	logic           boot_s1;

	logic [7:0] wram_mem [WRAM_DEPTH];
	logic [7:0] hram_mem [HRAM_DEPTH];
	logic [7:0] wram_rd_s1, hram_rd_s1;

	// architectural state
	logic [4:0] pend_q, en_q;
	logic [7:0] page_q, pos_q;
	logic       active_q, boot_q;

	logic stall;
	assign stall    = out_valid && !out_ready;
	assign in_ready = !stall;

	logic take;
	assign take = in_valid && in_ready;

	// access address and decode
	logic        acc, wr;
	logic [15:0] a;
	logic [3:0]  rg;
	logic [15:0] off;
	logic        is_tick_dma;
	logic [15:0] hoff;
	always_comb begin
		is_tick_dma = opcode == OP_TICK && active_q;
		acc = opcode == OP_READ || opcode == OP_WRITE || is_tick_dma;
		wr  = opcode == OP_WRITE;
		a   = is_tick_dma ? {page_q, pos_q} : address;
		hoff = a - ADDR_HRAM_LO;
		rg  = RG_NONE;
		off = '0;
		if (a <= 16'h00ff && boot_q) begin
			rg = RG_BOOT; off = a;
		end else if (a <= ADDR_CROM_END) begin
			rg = RG_CROM; off = a;
		end else if (a <= ADDR_VRAM_END) begin
			rg = RG_VRAM; off = a & BANK_MASK;
		end else if (a <= ADDR_CRAM_END) begin
			rg = RG_CRAM; off = a & BANK_MASK;
		end else if (a <= ADDR_WRAM_END) begin
			rg = RG_WRAM; off = a & BANK_MASK;
		end else if (a <= ADDR_OAM_END) begin
			rg = RG_OAM; off = {8'd0, a[7:0]};
		end else if (a == ADDR_JOY) begin
			rg = RG_JOY;
		end else if (a >= ADDR_TIMER_LO && a <= ADDR_TIMER_HI) begin
			rg = RG_TIMER; off = a;
		end else if (a == ADDR_IF) begin
			rg = RG_IF;
		end else if (a == ADDR_DMA) begin
			rg = RG_DMA;
		end else if (a >= ADDR_VIDEO_LO && a <= ADDR_VIDEO_HI) begin
			rg = RG_VIDEO; off = a;
		end else if (a == ADDR_BOOTOFF) begin
			rg = RG_BOOTOFF;
		end else if (a >= ADDR_HRAM_LO && a <= ADDR_HRAM_HI) begin
			rg = RG_HRAM; off = hoff;
		end else if (a == ADDR_IE) begin
			rg = RG_IE;
		end
		if (!acc) begin
			rg = RG_NONE; off = '0;
		end
	end

	// ram indexes, modulo depth
	logic [15:0] widx_full, hidx_full;
	logic [WAW-1:0] widx;
	logic [HAW-1:0] hidx;
	always_comb begin
		// offsets stay below twice each depth: one compare and subtract
		widx_full = (off >= 16'(WRAM_DEPTH)) ? off - 16'(WRAM_DEPTH) : off;
		hidx_full = (off >= 16'(HRAM_DEPTH)) ? off - 16'(HRAM_DEPTH) : off;
		widx = widx_full[WAW-1:0];
		hidx = hidx_full[HAW-1:0];
	end

	// next architectural state
	logic [4:0] pend_n, en_n;
	logic [7:0] page_n, pos_n, regdata;
	logic       active_n, boot_n;
	src_t       src;
	always_comb begin
		pend_n = pend_q; en_n = en_q; page_n = page_q; pos_n = pos_q;
		active_n = active_q; boot_n = boot_q;
		regdata = '0;
		src = SRC_NONE;
		case (rg)
			RG_BOOT:    if (!wr) begin src = SRC_REG; regdata = BOOT_IMAGE[a[7:0]]; end
			RG_WRAM:    if (!wr) src = SRC_WRAM;
			RG_HRAM:    if (!wr) src = SRC_HRAM;
			RG_IF: begin
				if (wr) pend_n = write_data[4:0] & IRQ_MASK[4:0];
				else begin src = SRC_REG; regdata = {3'd0, pend_q}; end
			end
			RG_IE: begin
				if (wr) en_n = write_data[4:0] & IRQ_MASK[4:0];
				else begin src = SRC_REG; regdata = {3'd0, en_q}; end
			end
			RG_DMA: begin
				if (wr) begin
					active_n = 1'b1; pos_n = '0; page_n = write_data;
				end else begin
					src = SRC_REG; regdata = page_q;
				end
			end
			RG_BOOTOFF: boot_n = 1'b0;
			default: ;
		endcase
		if (opcode == OP_RAISE)
			pend_n = pend_q | (irq_lines & en_q);
		if (opcode == OP_ACK && ack_index < 3'd5)
			pend_n = pend_q & ~(5'd1 << ack_index);
		if (is_tick_dma) begin
			if (9'(pos_q) + 9'd1 >= 9'(DMA_LENGTH)) begin
				active_n = 1'b0; pos_n = '0;
			end else begin
				pos_n = pos_q + 8'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0; en_q <= '0; page_q <= '0; pos_q <= '0;
			active_q <= 1'b0; boot_q <= 1'b1;
		end else if (take) begin
			pend_q <= pend_n; en_q <= en_n; page_q <= page_n; pos_q <= pos_n;
			active_q <= active_n; boot_q <= boot_n;
		end
	end

	// rams: one read or one write per transaction, read data registered
	always_ff @(posedge clk) begin
		if (take && rg == RG_WRAM && acc) begin
			if (wr) wram_mem[widx] <= write_data;
			else wram_rd_s1 <= wram_mem[widx];
		end
	end
	always_ff @(posedge clk) begin
		if (take && rg == RG_HRAM && acc) begin
			if (wr) hram_mem[hidx] <= write_data;
			else hram_rd_s1 <= hram_mem[hidx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (!stall) v_s1 <= take;
	end

	always_ff @(posedge clk) begin
		if (take) begin
			region_s1 <= rg; offset_s1 <= off; src_s1 <= src; regdata_s1 <= regdata;
			req_s1 <= is_tick_dma; oam_s1 <= is_tick_dma ? pos_q : 8'd0;
			busy_s1 <= active_n; pend_s1 <= pend_n & en_n; en_s1 <= en_n;
			boot_s1 <= boot_n;
		end
	end

	// output register
	logic [7:0] rdata;
	always_comb begin
		case (src_s1)
			SRC_REG:  rdata = regdata_s1;
			SRC_WRAM: rdata = wram_rd_s1;
			SRC_HRAM: rdata = hram_rd_s1;
			default:  rdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (!stall) out_valid <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (!stall && v_s1) begin
			region <= region_s1; local_offset <= offset_s1; read_data <= rdata;
			data_internal <= src_s1 != SRC_NONE; dma_request <= req_s1;
			dma_oam_index <= oam_s1; dma_busy <= busy_s1; pending_irqs <= pend_s1;
			enabled_irqs <= en_s1; boot_overlay_on <= boot_s1;
		end
	end
endmodule

// ===== rtl/mbd_checker.sv =====
// port-level checker for the memory bus decoder, bound to the top level
`timescale 1ns / 1ps
module mbd_checker import mbd_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [3:0]  region,
	input logic [15:0] local_offset,
	input logic        data_internal,
	input logic [7:0]  read_data,
	input logic        dma_request,
	input logic [7:0]  dma_oam_index,
	input logic [4:0]  pending_irqs,
	input logic [4:0]  enabled_irqs
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(region) && $stable(local_offset))
		else $error("result dropped while stalled");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input blocked with empty output");
	a_pend: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (pending_irqs & ~enabled_irqs) == 5'd0)
		else $error("pending irq not enabled");
	a_ext: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (region == RG_NONE || region == RG_CROM) |-> !data_internal
		&& read_data == 8'd0)
		else $error("external region returned internal data");
	a_dma: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !dma_request |-> dma_oam_index == 8'd0)
		else $error("oam index without dma");
endmodule

bind memory_bus_decoder_with_irq_and_dma mbd_checker u_mbd_checker (.*);
